FILE: rtl/wdt_pkg.sv
// Shared types, constants and helpers for the watchdog/interval timer.
`default_nettype none

package wdt_pkg;

  // Item commands
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_PIN   = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMER_VECTOR = 2'd0;
  localparam logic [1:0] CFG_TIMER_IEN    = 2'd1;
  localparam logic [1:0] CFG_NMI_IEN      = 2'd2;

  localparam logic [15:0] CTL_ADDR = 16'h0120;
  localparam logic [7:0]  PASSWORD = 8'h5A;
  localparam logic [15:0] READ_PW  = 16'h6900;
  localparam logic [7:0]  CTL_KEEP = 8'hF7;

  // Control byte bit positions
  localparam int SSEL_BIT  = 2;
  localparam int CNTCL_BIT = 3;
  localparam int TMSEL_BIT = 4;
  localparam int NMI_BIT   = 5;
  localparam int NMIES_BIT = 6;
  localparam int HOLD_BIT  = 7;

  localparam logic [3:0] VEC_RESET = 4'd15;
  localparam logic [3:0] VEC_NMI   = 4'd14;
  localparam logic [3:0] TIMER_VECTOR_RST = 4'd10;

  localparam int CNT_W = 15;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [15:0] aclk_ticks;
    logic [15:0] smclk_ticks;
    logic        pin_level;
    logic [3:0]  ack_vector;
  } item_t;

  typedef struct packed {
    logic        claimed;
    logic [15:0] read_data;
    logic        irq_valid;
    logic [3:0]  irq_vector;
    logic        reset_request;
  } res_t;

  // Interval length minus one for each interval select: 32768, 8192, 512, 64
  function automatic logic [CNT_W-1:0] interval_mask(input logic [1:0] sel);
    logic [CNT_W-1:0] m;
    case (sel)
      2'd0:    m = 15'h7FFF;
      2'd1:    m = 15'h1FFF;
      2'd2:    m = 15'h01FF;
      2'd3:    m = 15'h003F;
      default: m = 15'h7FFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/watchdog_interval_timer_top.sv
// Top level of the watchdog/interval timer: input stage, core and result register.
// The item beat is held in the input stage register and then in the result
// register, where out_valid marks it until the result beat leaves.
// Throughput: one item per cycle while out_ready is high; the input register and
// result register overlap, so a new item is taken while a finished result waits.
// Reset (rst, synchronous): control 0, counter 0, pin high, flags clear,
// timer vector 10, interrupt enables off, both pipeline stages empty.
`default_nettype none

module watchdog_interval_timer_top import wdt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [15:0] addr,
  input  wire logic [15:0] wdata,
  input  wire logic [15:0] aclk_ticks,
  input  wire logic [15:0] smclk_ticks,
  input  wire logic        pin_level,
  input  wire logic [3:0]  ack_vector,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             claimed,
  output logic [15:0]      read_data,
  output logic             irq_valid,
  output logic [3:0]       irq_vector,
  output logic             reset_request
);

  item_t in_item;
  item_t stg_item;
  logic  stg_valid;
  logic  fire;
  res_t  res;
  res_t  res_q;

  assign in_item.cmd         = cmd;
  assign in_item.addr        = addr;
  assign in_item.wdata       = wdata;
  assign in_item.aclk_ticks  = aclk_ticks;
  assign in_item.smclk_ticks = smclk_ticks;
  assign in_item.pin_level   = pin_level;
  assign in_item.ack_vector  = ack_vector;

  assign cfg_ready = 1'b1;
  // Advance the staged item when the result register is free or draining
  assign fire = stg_valid && (!out_valid || out_ready);

  wdt_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take      (fire),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  wdt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (stg_item),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign claimed       = res_q.claimed;
  assign read_data     = res_q.read_data;
  assign irq_valid     = res_q.irq_valid;
  assign irq_vector    = res_q.irq_vector;
  assign reset_request = res_q.reset_request;

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stg_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline can move");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stg_valid))
    else $error("result appeared without a staged item");

  a_reset_wins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reset_request) |-> (irq_valid && irq_vector == VEC_RESET))
    else $error("reset request not reported as top priority");

  a_read_needs_claim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_data != 16'h0000) |-> claimed)
    else $error("read data on an unclaimed access");

endmodule

`default_nettype wire

FILE: rtl/wdt_in_stage.sv
// Input register stage: captures one item beat and holds it until the core takes it.
`default_nettype none

module wdt_in_stage import wdt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       stg_valid,
  output item_t      stg_item
);

  assign in_ready = !stg_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wdt_core.sv
// Timer state, configuration registers and the per-item update with its result.
`default_nettype none

module wdt_core import wdt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       fire,
  input  wire item_t      item,
  output res_t            res
);

  logic [3:0]       timer_vector;
  logic             timer_ien;
  logic             nmi_ien;

  logic [7:0]       ctl, ctl_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             rst_lat, rst_lat_next;
  logic             pin, pin_next;
  logic             tflag, tflag_next;
  logic             nflag, nflag_next;

  logic [CNT_W-1:0] mask;
  logic [16:0]      sum;
  logic [16:0]      lim;
  logic [15:0]      ticks;
  logic             nmi_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_vector <= TIMER_VECTOR_RST;
      timer_ien    <= 1'b0;
      nmi_ien      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_VECTOR: timer_vector <= cfg_data;
        CFG_TIMER_IEN:    timer_ien    <= cfg_data[0];
        CFG_NMI_IEN:      nmi_ien      <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  assign mask  = interval_mask(ctl[1:0]);
  assign ticks = ctl[SSEL_BIT] ? item.aclk_ticks : item.smclk_ticks;
  // Full-width sum so a long tick gives a single overflow event
  assign sum   = {2'b00, cnt} + {1'b0, ticks};
  assign lim   = {2'b00, mask} + 17'd1;
  assign nmi_edge = ctl[NMIES_BIT] ? (pin && !item.pin_level)
                                   : (!pin && item.pin_level);

  always_comb begin
    ctl_next      = ctl;
    cnt_next      = cnt;
    rst_lat_next  = rst_lat;
    pin_next      = pin;
    tflag_next    = tflag;
    nflag_next    = nflag;
    res.claimed   = 1'b0;
    res.read_data = 16'h0000;
    case (item.cmd)
      CMD_TICK: begin
        if (!ctl[HOLD_BIT]) begin
          if (sum >= lim) begin
            if (ctl[TMSEL_BIT]) tflag_next = 1'b1;
            else rst_lat_next = 1'b1;
          end
          cnt_next = sum[CNT_W-1:0] & mask;
        end
      end
      CMD_WRITE: begin
        if (item.addr == CTL_ADDR) begin
          res.claimed = 1'b1;
          if (item.wdata[15:8] != PASSWORD) rst_lat_next = 1'b1;
          if (item.wdata[CNTCL_BIT]) cnt_next = '0;
          ctl_next = item.wdata[7:0] & CTL_KEEP;
        end
      end
      CMD_READ: begin
        if (item.addr == CTL_ADDR) begin
          res.claimed   = 1'b1;
          res.read_data = READ_PW | {8'h00, ctl};
        end
      end
      CMD_PIN: begin
        pin_next = item.pin_level;
        if (ctl[NMI_BIT] && nmi_edge) nflag_next = 1'b1;
      end
      CMD_ACK: begin
        if (item.ack_vector == VEC_NMI) nflag_next = 1'b0;
        else if (item.ack_vector == timer_vector) tflag_next = 1'b0;
      end
      default: ;
    endcase

    // Report the highest-priority request seen after the update
    res.irq_valid  = 1'b1;
    res.irq_vector = 4'd0;
    if ((!ctl_next[NMI_BIT] && !pin_next) || rst_lat_next) begin
      res.irq_vector = VEC_RESET;
    end else if (nflag_next && nmi_ien) begin
      res.irq_vector = VEC_NMI;
    end else if (tflag_next && timer_ien) begin
      res.irq_vector = timer_vector;
    end else begin
      res.irq_valid = 1'b0;
    end
    res.reset_request = rst_lat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl     <= '0;
      cnt     <= '0;
      rst_lat <= 1'b0;
      pin     <= 1'b1;
      tflag   <= 1'b0;
      nflag   <= 1'b0;
    end else if (fire) begin
      ctl     <= ctl_next;
      cnt     <= cnt_next;
      rst_lat <= rst_lat_next;
      pin     <= pin_next;
      tflag   <= tflag_next;
      nflag   <= nflag_next;
    end
  end

endmodule

`default_nettype wire
